@@ rtl/ehs_pkg.sv @@
// ehs_pkg: shared constants, register codes and structs of the hybrid stereo matcher
// used by ehs_cfg, ehs_match and edge_hausdorff_hybrid_stereo; no dependencies
package ehs_pkg;

  localparam int MaxWidth    = 1024;
  localparam int MaxWindow   = 15;
  localparam int MaxDisp     = 64;
  localparam int HeightLimit = 1024;

  localparam int ColW   = $clog2(MaxWidth);
  localparam int SlotW  = $clog2(MaxWindow + 1);
  localparam int Depth  = MaxWindow * MaxWidth;
  localparam int AddrW  = $clog2(Depth);
  localparam int WordW  = 9;
  localparam int CostW  = 24;
  localparam int CntW   = 8;
  localparam int DispW  = 6;
  localparam int CfgW   = 11;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWindowSize  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDispCount   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMatchMode   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgFill        = 3'd5;

  localparam logic [1:0] ModeEdge     = 2'd0;
  localparam logic [1:0] ModeCentre   = 2'd1;
  localparam logic [1:0] ModeFraction = 2'd2;

  // effective (clamped) configuration
  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [3:0]  ws;
    logic [6:0]  nd;
    logic [1:0]  mode;
    logic [7:0]  fill;
  } cfg_t;

  // one window job for the score engine
  typedef struct packed {
    logic [ColW-1:0]  lo;
    logic [SlotW-1:0] top_slot;
    logic [3:0]       ws;
    logic [2:0]       half;
    logic [6:0]       nd;
    logic [7:0]       fill;
  } job_t;

  typedef struct packed {
    logic [DispW-1:0] best_e;
    logic [DispW-1:0] best_s;
    logic [CntW-1:0]  best_hits;
    logic [CntW-1:0]  edges;
    logic             centre_edge;
  } score_t;

endpackage

@@ rtl/ehs_ram.sv @@
// ehs_ram: generic single write, single read port ram with registered read
// no dependencies
module ehs_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/ehs_cfg.sv @@
// ehs_cfg: configuration registers with range clamping
// depends on ehs_pkg
module ehs_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [ehs_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [ehs_pkg::CfgW-1:0]     wdata_i,
  output ehs_pkg::cfg_t                cfg_o
);

  logic [10:0] width_q, height_q;
  logic [3:0]  ws_q;
  logic [6:0]  nd_q;
  logic [1:0]  mode_q;
  logic [7:0]  fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 11'd480;
      ws_q     <= 4'd7;
      nd_q     <= 7'd32;
      mode_q   <= ehs_pkg::ModeFraction;
      fill_q   <= 8'd0;
    end else if (we_i) begin
      case (idx_i)
        ehs_pkg::CfgImageWidth:  width_q  <= wdata_i;
        ehs_pkg::CfgImageHeight: height_q <= wdata_i;
        ehs_pkg::CfgWindowSize:  ws_q     <= wdata_i[3:0];
        ehs_pkg::CfgDispCount:   nd_q     <= wdata_i[6:0];
        ehs_pkg::CfgMatchMode:   mode_q   <= wdata_i[1:0];
        ehs_pkg::CfgFill:        fill_q   <= wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.width  = (width_q < 11'd2) ? 11'd2 :
                   (width_q > 11'(ehs_pkg::MaxWidth)) ? 11'(ehs_pkg::MaxWidth) : width_q;
    cfg_o.height = (height_q < 11'd2) ? 11'd2 :
                   (height_q > 11'(ehs_pkg::HeightLimit)) ? 11'(ehs_pkg::HeightLimit)
                                                           : height_q;
    cfg_o.ws     = (ws_q == 4'd0) ? 4'd1 :
                   (ws_q > 4'(ehs_pkg::MaxWindow)) ? 4'(ehs_pkg::MaxWindow) : ws_q;
    cfg_o.nd     = (nd_q > 7'(ehs_pkg::MaxDisp)) ? 7'(ehs_pkg::MaxDisp) : nd_q;
    cfg_o.mode   = mode_q;
    cfg_o.fill   = fill_q;
  end

endmodule

@@ rtl/ehs_match.sv @@
// ehs_match: line stores plus the per-disparity window scan (edge hits and ssd)
// depends on ehs_pkg and ehs_ram
module ehs_match (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [ehs_pkg::AddrW-1:0]   wr_addr_i,
  input  logic [ehs_pkg::WordW-1:0]   wr_left_i,
  input  logic [ehs_pkg::WordW-1:0]   wr_right_i,
  input  logic                        start_i,
  input  ehs_pkg::job_t               job_i,
  output logic                        done_o,
  output ehs_pkg::score_t             score_o
);

  ehs_pkg::job_t job_q;
  logic        busy_q;
  logic [6:0]  d_q;
  logic [3:0]  i_q, j_q;
  logic [ehs_pkg::SlotW-1:0] slot_q;

  logic [6:0]  passes;
  logic [3:0]  ws_m1;
  logic        row_end, pass_end, last_pass;
  logic [ehs_pkg::ColW-1:0] cc, rc;
  logic        off;
  logic [ehs_pkg::WordW-1:0] ldata, rdata;

  assign passes    = (job_q.nd == 7'd0) ? 7'd1 : job_q.nd;
  assign ws_m1     = job_q.ws - 4'd1;
  assign row_end   = (j_q == ws_m1);
  assign pass_end  = row_end && (i_q == ws_m1);
  assign last_pass = (d_q == passes - 7'd1);
  assign cc        = job_q.lo + ehs_pkg::ColW'(j_q);
  assign rc        = cc - ehs_pkg::ColW'(d_q);
  assign off       = (cc <= ehs_pkg::ColW'(d_q));

  ehs_ram #(.Width(ehs_pkg::WordW), .Depth(ehs_pkg::Depth)) u_left (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_left_i),
    .raddr_i({slot_q, cc}),
    .rdata_o(ldata)
  );

  ehs_ram #(.Width(ehs_pkg::WordW), .Depth(ehs_pkg::Depth)) u_right (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_right_i),
    .raddr_i({slot_q, rc}),
    .rdata_o(rdata)
  );

  // scan: j fastest, then window row, then disparity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && pass_end && last_pass) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      job_q  <= job_i;
      d_q    <= 7'd0;
      i_q    <= 4'd0;
      j_q    <= 4'd0;
      slot_q <= job_i.top_slot;
    end else if (busy_q) begin
      if (!row_end) begin
        j_q <= j_q + 4'd1;
      end else begin
        j_q <= 4'd0;
        if (pass_end) begin
          i_q    <= 4'd0;
          slot_q <= job_q.top_slot;
          d_q    <= d_q + 7'd1;
        end else begin
          i_q    <= i_q + 4'd1;
          slot_q <= (slot_q == ehs_pkg::SlotW'(ehs_pkg::MaxWindow - 1)) ?
                    '0 : slot_q + 1'b1;
        end
      end
    end
  end

  // read-side tags, aligned with ram data
  localparam int DispWm1 = ehs_pkg::DispW - 1;
  logic p_valid_q, p_off_q, p_centre_q, p_first_q, p_end_q, p_final_q, p_upd_q;
  logic [DispWm1:0] p_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_off_q    <= off;
    p_centre_q <= (d_q == 7'd0) && (i_q == {1'b0, job_q.half}) && (j_q == {1'b0, job_q.half});
    p_first_q  <= (d_q == 7'd0);
    p_end_q    <= pass_end;
    p_final_q  <= pass_end && last_pass;
    p_upd_q    <= (d_q < job_q.nd);
    p_d_q      <= d_q[ehs_pkg::DispW-1:0];
  end

  // accumulate
  logic [7:0]  lv, rv, adiff;
  logic        le, re, hit;
  logic [15:0] sq;
  logic [ehs_pkg::CntW-1:0]  hits_acc_q, hits_tot, edges_q, best_hits_q;
  logic [ehs_pkg::CostW-1:0] cost_acc_q, cost_tot, best_cost_q;
  logic [ehs_pkg::DispW-1:0] best_e_q, best_s_q;
  logic centre_q, done_q;

  assign lv       = ldata[7:0];
  assign le       = ldata[8];
  assign rv       = p_off_q ? job_q.fill : rdata[7:0];
  assign re       = p_off_q ? 1'b0 : rdata[8];
  assign hit      = le & re;
  assign adiff    = (lv >= rv) ? lv - rv : rv - lv;
  assign sq       = adiff * adiff;
  assign hits_tot = hits_acc_q + ehs_pkg::CntW'(hit);
  assign cost_tot = cost_acc_q + ehs_pkg::CostW'(sq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= p_valid_q && p_final_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hits_acc_q  <= '0;
      cost_acc_q  <= '0;
      edges_q     <= '0;
      best_hits_q <= '0;
      best_cost_q <= '1;
      best_e_q    <= '0;
      best_s_q    <= '0;
      centre_q    <= 1'b0;
    end else if (p_valid_q) begin
      if (p_first_q) begin
        edges_q <= edges_q + ehs_pkg::CntW'(le);
      end
      if (p_centre_q) begin
        centre_q <= le;
      end
      if (p_end_q) begin
        hits_acc_q <= '0;
        cost_acc_q <= '0;
        if (p_upd_q && hits_tot > best_hits_q) begin
          best_hits_q <= hits_tot;
          best_e_q    <= p_d_q;
        end
        if (p_upd_q && cost_tot < best_cost_q) begin
          best_cost_q <= cost_tot;
          best_s_q    <= p_d_q;
        end
      end else begin
        hits_acc_q <= hits_tot;
        cost_acc_q <= cost_tot;
      end
    end
  end

  assign done_o              = done_q;
  assign score_o.best_e      = best_e_q;
  assign score_o.best_s      = best_s_q;
  assign score_o.best_hits   = best_hits_q;
  assign score_o.edges       = edges_q;
  assign score_o.centre_edge = centre_q;

endmodule

@@ rtl/edge_hausdorff_hybrid_stereo.sv @@
// edge_hausdorff_hybrid_stereo: hybrid edge-count / ssd block-matching stereo top level
// interior pixel: the window is scanned once for each of max(disparity_count,1) disparities,
// one window sample per cycle; next pixel taken on leaving ST_DONE; border pixels give no result
// one pixel in flight at a time; a finished result waits in ST_DONE, then in the output register
// reset: counters to zero, registers to 640/480/7/32/2/0, line stores left unwritten
// depends on ehs_pkg, ehs_cfg, ehs_match, ehs_ram
module edge_hausdorff_hybrid_stereo (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // left_pixel[7:0], right_pixel[15:8], left_edge[16],
                                     // right_edge[17], zero pad
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_col[9:0], out_row[19:10], disparity[25:20], zero pad
  output logic        m_axis_tuser,  // edge_method_used
  output logic        m_axis_tlast,  // frame_last
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [ehs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ehs_pkg::CfgW-1:0]     cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  ehs_pkg::cfg_t   cfg;
  ehs_pkg::job_t   job;
  ehs_pkg::score_t score;
  logic eng_done;

  ehs_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .wdata_i(cfg_wdata_i),
    .cfg_o  (cfg)
  );

  // raster position; slot tracks row modulo the line-store height
  logic [ehs_pkg::ColW-1:0]  col_q, row_q;
  logic [ehs_pkg::SlotW-1:0] slot_q;
  logic accept;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  function automatic logic [ehs_pkg::SlotW-1:0] slot_inc(input logic [ehs_pkg::SlotW-1:0] s);
    return (s == ehs_pkg::SlotW'(ehs_pkg::MaxWindow - 1)) ? '0 : s + 1'b1;
  endfunction

  // position of this beat (counters may sit past a shrunken size)
  logic        col_wrap, row_wrap, c_end, r_end;
  logic [10:0] row_tmp, col_nx, row_nx;
  logic [ehs_pkg::ColW-1:0]  c, r;
  logic [ehs_pkg::SlotW-1:0] slot_tmp, s_cur;
  logic [3:0]  ws_m1, box_rad;
  logic [4:0]  top_tmp;
  logic        interior, flast;

  always_comb begin
    col_wrap = ({1'b0, col_q} >= cfg.width);
    row_tmp  = {1'b0, row_q} + 11'(col_wrap);
    slot_tmp = col_wrap ? slot_inc(slot_q) : slot_q;
    row_wrap = (row_tmp >= cfg.height);
    c        = col_wrap ? '0 : col_q;
    r        = row_wrap ? '0 : row_tmp[ehs_pkg::ColW-1:0];
    s_cur    = row_wrap ? '0 : slot_tmp;

    col_nx   = {1'b0, c} + 11'd1;
    row_nx   = {1'b0, r} + 11'd1;
    c_end    = (col_nx >= cfg.width);
    r_end    = (row_nx >= cfg.height);

    ws_m1    = cfg.ws - 4'd1;
    box_rad  = ws_m1 >> 1;
    interior = (r >= ehs_pkg::ColW'(ws_m1)) && (c >= ehs_pkg::ColW'(ws_m1));
    flast    = (col_nx == cfg.width) && (row_nx == cfg.height);

    // window top row slot, modulo the store height
    top_tmp  = {1'b0, s_cur} + 5'(ehs_pkg::MaxWindow) - {1'b0, ws_m1};
    if (top_tmp >= 5'(ehs_pkg::MaxWindow)) begin
      top_tmp = top_tmp - 5'(ehs_pkg::MaxWindow);
    end

    job.lo       = c - ehs_pkg::ColW'(ws_m1);
    job.top_slot = top_tmp[ehs_pkg::SlotW-1:0];
    job.ws       = cfg.ws;
    job.half     = cfg.ws[3:1];
    job.nd       = cfg.nd;
    job.fill     = cfg.fill;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept) begin
      if (!c_end) begin
        col_q  <= col_nx[ehs_pkg::ColW-1:0];
        row_q  <= r;
        slot_q <= s_cur;
      end else begin
        col_q  <= '0;
        row_q  <= r_end ? '0 : row_nx[ehs_pkg::ColW-1:0];
        slot_q <= r_end ? '0 : slot_inc(s_cur);
      end
    end
  end

  // window scan engine with the line stores
  ehs_match u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_addr_i ({s_cur, c}),
    .wr_left_i ({s_axis_tdata[16], s_axis_tdata[7:0]}),
    .wr_right_i({s_axis_tdata[17], s_axis_tdata[15:8]}),
    .start_i   (accept && interior),
    .job_i     (job),
    .done_o    (eng_done),
    .score_o   (score)
  );

  // pixel bookkeeping for the result
  logic [ehs_pkg::ColW-1:0] x_q, y_q;
  logic flast_q;
  logic [1:0] mode_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= c - ehs_pkg::ColW'(box_rad);
      y_q     <= r - ehs_pkg::ColW'(box_rad);
      flast_q <= flast;
      mode_q  <= cfg.mode;
    end
  end

  // method choice: edge only, edge at edge centres, or fallback below 3/4 hit fraction
  logic [9:0] hits_x4, edges_x3;
  logic use_edge;
  logic [ehs_pkg::DispW-1:0] disp;

  always_comb begin
    hits_x4  = {score.best_hits, 2'b00};
    edges_x3 = {2'b00, score.edges} + {1'b0, score.edges, 1'b0};
    case (mode_q)
      ehs_pkg::ModeEdge:   use_edge = 1'b1;
      ehs_pkg::ModeCentre: use_edge = score.centre_edge;
      default:             use_edge = (score.edges != '0) && !(hits_x4 < edges_x3);
    endcase
    disp = use_edge ? score.best_e : score.best_s;
  end

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && interior) state_d = ST_BUSY;
      ST_BUSY: if (eng_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      m_axis_tdata <= {6'd0, disp, y_q, x_q};
      m_axis_tuser <= use_edge;
      m_axis_tlast <= flast_q;
    end
  end

`ifndef SYNTHESIS
  // a finished window is always presented on the next edge once the register is free
  a_done_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> m_axis_tvalid)
    else $error("result not presented after window scan");

  // the engine only finishes while a pixel is being scored
  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_done |-> (state_q == ST_BUSY))
    else $error("engine finished outside of a scan");

  // no line-store write while a scan reads the stores
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUSY) |-> !accept)
    else $error("input accepted during a scan");
`endif

endmodule
